[hdl/sha256_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sha256_pkg;

  // Block geometry and padding constants
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned FILL_W      = 7;
  localparam int unsigned LEN_POS     = 56;
  localparam int unsigned ROUNDS      = 64;
  localparam int unsigned ROUND_W     = 6;
  localparam int unsigned COUNT_W     = 61;
  localparam int unsigned WORDS       = 8;
  localparam int unsigned WORD_IDX_W  = 3;
  localparam int unsigned MSG_W       = 512;
  localparam logic [7:0]  PAD_MARK    = 8'h80;

  // Initial hash value
  localparam logic [31:0] SHA_INIT [WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam logic [31:0] SHA_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Controls for the message register
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_data;
    logic       expand;
  } msg_ctrl_t;

  // Controls for the compression core
  typedef struct packed {
    logic load;
    logic round;
    logic update;
    logic reinit;
  } core_ctrl_t;

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

[hdl/sha256_msg.sv]
`timescale 1ns / 1ps
`default_nettype none

module sha256_msg
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire msg_ctrl_t   ctrl,
  output logic [31:0]      w_cur
);

  // Word k of the window sits at msg[MSG_W-1-32k -: 32]; word 0 is the oldest
  logic [MSG_W-1:0] msg;
  logic [31:0]      w_new;

  assign w_cur = msg[MSG_W-1 -: 32];

  // Expand the schedule: W16 from W14, W9, W1 and W0 of the window
  assign w_new = small_sigma1(msg[63:32]) + msg[223:192]
               + small_sigma0(msg[479:448]) + msg[511:480];

  // Shift bytes in while filling, words while running rounds
  always_ff @(posedge clk) begin
    if (ctrl.shift_byte) begin
      msg <= {msg[MSG_W-9:0], ctrl.byte_data};
    end else if (ctrl.expand) begin
      msg <= {msg[MSG_W-33:0], w_new};
    end
  end

endmodule

`default_nettype wire

[hdl/sha256_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module sha256_core
  import sha256_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire core_ctrl_t            ctrl,
  input  wire logic [31:0]           w_cur,
  input  wire logic [31:0]           k_cur,
  input  wire logic [WORD_IDX_W-1:0] word_sel,
  output logic [31:0]                digest
);

  logic [31:0] hash [WORDS];
  logic [31:0] wv   [WORDS];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  // One compression round on the working variables
  always_comb begin
    ch  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    maj = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    t1  = wv[7] + big_sigma1(wv[4]) + ch + k_cur + w_cur;
    t2  = big_sigma0(wv[0]) + maj;
  end

  // Load from the hash state, or advance one round
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      for (int j = 0; j < WORDS; j++) begin
        wv[j] <= hash[j];
      end
    end else if (ctrl.round) begin
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
  end

  // Fold the working variables into the hash state; restore after a digest
  always_ff @(posedge clk) begin
    if (rst || ctrl.reinit) begin
      for (int j = 0; j < WORDS; j++) begin
        hash[j] <= SHA_INIT[j];
      end
    end else if (ctrl.update) begin
      for (int j = 0; j < WORDS; j++) begin
        hash[j] <= hash[j] + wv[j];
      end
    end
  end

  assign digest = hash[word_sel];

endmodule

`default_nettype wire

[hdl/sha256_hash_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// input     in_valid / in_stall    msg_byte, byte_present, final_item
// output    out_valid / out_stall  digest_word, word_number, last_word
//
// A message byte is taken while in_stall is low. Each full 64-byte block costs one load,
// 64 rounds of the shared round unit and one hash update, during which in_stall is high.
// A final item adds the padding bytes, one or two compressions, then eight output
// transfers. Reset is synchronous and restores the initial hash value at once.
// out_stall holds the current digest word.
module sha256_hash_engine
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  msg_byte,
  input  wire logic        byte_present,
  input  wire logic        final_item,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_number,
  output logic             last_word
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ROUND = 6'b000100,
    S_UPD   = 6'b001000,
    S_PAD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  logic [FILL_W-1:0]       fill;
  logic [FILL_W-1:0]       fill_next;
  logic [COUNT_W-1:0]      bytes_seen;
  logic [ROUND_W-1:0]      round_cnt;
  logic [WORD_IDX_W-1:0]   word_cnt;
  logic                    pad_active;
  logic                    marker_done;
  logic                    len_block;

  logic                    in_fire;
  logic                    out_fire;
  logic                    take_byte;
  logic [63:0]             len_shift;
  logic [7:0]              pad_byte;
  logic [31:0]             w_cur;
  logic [31:0]             digest;
  msg_ctrl_t               mctrl;
  core_ctrl_t              cctrl;

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (state == S_OUT);
  assign out_fire  = out_valid && !out_stall;
  assign take_byte = in_fire && byte_present;

  // Pick the padding byte: marker, zero fill or big-endian bit length
  assign len_shift = {bytes_seen, 3'b000} >> {~fill[2:0], 3'b000};
  always_comb begin
    if (!marker_done) begin
      pad_byte = PAD_MARK;
    end else if (len_block && (fill >= FILL_W'(LEN_POS))) begin
      pad_byte = len_shift[7:0];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Sequence the block: fill, load, rounds, update, padding, output
  always_comb begin
    state_next = state;
    fill_next  = fill;
    case (state)
      S_IDLE: begin
        if (take_byte) begin
          fill_next = fill + 1'b1;
        end
        if (take_byte && (fill == FILL_W'(BLOCK_BYTES - 1))) begin
          state_next = S_LOAD;
        end else if (in_fire && final_item) begin
          state_next = S_PAD;
        end
      end
      S_LOAD: begin
        fill_next  = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        if (round_cnt == ROUND_W'(ROUNDS - 1)) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (!pad_active) begin
          state_next = S_IDLE;
        end else if (marker_done && len_block) begin
          state_next = S_OUT;
        end else begin
          state_next = S_PAD;
        end
      end
      S_PAD: begin
        fill_next = fill + 1'b1;
        if (fill == FILL_W'(BLOCK_BYTES - 1)) begin
          state_next = S_LOAD;
        end
      end
      S_OUT: begin
        if (out_fire && (word_cnt == WORD_IDX_W'(WORDS - 1))) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fill        <= '0;
      bytes_seen  <= '0;
      round_cnt   <= '0;
      word_cnt    <= '0;
      pad_active  <= 1'b0;
      marker_done <= 1'b0;
      len_block   <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (take_byte) begin
        bytes_seen <= bytes_seen + 1'b1;
      end
      if (in_fire && final_item) begin
        pad_active  <= 1'b1;
        marker_done <= 1'b0;
        len_block   <= 1'b0;
      end
      if (state == S_LOAD) begin
        round_cnt <= '0;
      end else if (state == S_ROUND) begin
        round_cnt <= round_cnt + 1'b1;
      end
      // Length goes in this block only if the marker leaves room for it
      if ((state == S_PAD) && !marker_done) begin
        marker_done <= 1'b1;
        len_block   <= (fill < FILL_W'(LEN_POS));
      end
      if ((state == S_UPD) && pad_active && marker_done) begin
        len_block <= 1'b1;
      end
      if (state == S_UPD) begin
        word_cnt <= '0;
      end else if (out_fire) begin
        word_cnt <= word_cnt + 1'b1;
      end
      // Drop the message state once the last word has gone
      if (out_fire && (word_cnt == WORD_IDX_W'(WORDS - 1))) begin
        bytes_seen <= '0;
        pad_active <= 1'b0;
      end
    end
  end

  // Steer the message register and the core
  always_comb begin
    mctrl.shift_byte = take_byte || (state == S_PAD);
    mctrl.byte_data  = (state == S_PAD) ? pad_byte : msg_byte;
    mctrl.expand     = (state == S_ROUND);
    cctrl.load       = (state == S_LOAD);
    cctrl.round      = (state == S_ROUND);
    cctrl.update     = (state == S_UPD);
    cctrl.reinit     = out_fire && (word_cnt == WORD_IDX_W'(WORDS - 1));
  end

  sha256_msg u_msg (
    .clk   (clk),
    .ctrl  (mctrl),
    .w_cur (w_cur)
  );

  sha256_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (cctrl),
    .w_cur    (w_cur),
    .k_cur    (SHA_K[round_cnt]),
    .word_sel (word_cnt),
    .digest   (digest)
  );

  assign digest_word = digest;
  assign word_number = word_cnt;
  assign last_word   = (word_cnt == WORD_IDX_W'(WORDS - 1));

endmodule

`default_nettype wire

[tb/tb_sha256_hash_engine.sv]
`timescale 1ns / 1ps

module tb_sha256_hash_engine;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_TARGET = 460;
  localparam int unsigned LONG_HOLD   = 3000;
  localparam int unsigned HOLD_AT     = 60;
  localparam int unsigned DRAIN_WAIT  = 300;

  // Initial chaining value, independent of the design package
  localparam bit [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants
  localparam bit [31:0] RND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Running hash of the byte stream and the digest words still owed
  class digest_tracker;
    typedef struct {
      bit [31:0] word;
      bit [2:0]  pos;
      bit        last;
    } digest_word_t;

    bit [31:0]    chain [8];
    bit [7:0]     blk [64];
    int unsigned  fill;
    bit [60:0]    msg_len;
    digest_word_t due_words [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      foreach (chain[j]) chain[j] = IV[j];
      fill    = 0;
      msg_len = '0;
    endfunction

    function bit [31:0] ror(bit [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    // Run the 64 rounds over the buffered block and fold into the chain
    function void absorb_block();
      bit [31:0] w [64];
      bit [31:0] v [8];
      bit [31:0] t1;
      bit [31:0] t2;
      for (int t = 0; t < 16; t++)
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      for (int t = 16; t < 64; t++)
        w[t] = (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
             + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      foreach (v[j]) v[j] = chain[j];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RND_K[t] + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      foreach (chain[j]) chain[j] += v[j];
    endfunction

    // Note an accepted input transfer
    function void take_item(bit [7:0] b, bit present, bit fin);
      bit [63:0]    bit_len;
      digest_word_t dw;
      if (present) begin
        blk[fill] = b;
        fill++;
        msg_len++;
        if (fill == 64) begin
          absorb_block();
          fill = 0;
        end
      end
      if (!fin) return;
      // Pad: marker byte, zeros, then the big-endian bit count
      blk[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin
          blk[fill] = 8'h00;
          fill++;
        end
        absorb_block();
        fill = 0;
      end
      while (fill < 56) begin
        blk[fill] = 8'h00;
        fill++;
      end
      bit_len = {msg_len, 3'b000};
      for (int j = 0; j < 8; j++) blk[56 + j] = bit_len[63 - 8*j -: 8];
      absorb_block();
      for (int j = 0; j < 8; j++) begin
        dw.word = chain[j];
        dw.pos  = 3'(j);
        dw.last = (j == 7);
        due_words.push_back(dw);
      end
      restart();
    endfunction

    // Compare an output transfer with the oldest owed word
    function void match_word(bit [31:0] word, bit [2:0] pos, bit last);
      digest_word_t dw;
      if (due_words.size() == 0) begin
        $error("digest word %h arrived with none owed", word);
        mismatches++;
        return;
      end
      dw = due_words.pop_front();
      if (word !== dw.word) begin
        $error("digest_word: expected %h, got %h", dw.word, word);
        mismatches++;
      end
      if (pos !== dw.pos) begin
        $error("word_number: expected %0d, got %0d", dw.pos, pos);
        mismatches++;
      end
      if (last !== dw.last) begin
        $error("last_word: expected %0d, got %0d", dw.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  msg_byte;
  logic        byte_present;
  logic        final_item;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  digest_tracker track = new();
  int unsigned   stream_items = 0;
  int unsigned   words_seen = 0;
  int unsigned   cycles = 0;
  bit            tx_burst = 0;
  bit            rx_burst = 0;

  sha256_hash_engine dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .msg_byte     (msg_byte),
    .byte_present (byte_present),
    .final_item   (final_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_number  (word_number),
    .last_word    (last_word)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Offer one item after a drawn gap and hold it until the transfer
  task automatic send_item(input logic [7:0] b, input logic present, input logic fin);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    msg_byte     <= b;
    byte_present <= present;
    final_item   <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track.take_item(b, present, fin);
    if (present || fin) stream_items++;
  endtask

  // Send a message of random bytes, ended on its last byte or by a bare end
  task automatic send_message(input int unsigned len, input bit bare_end);
    tx_burst = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      // drop in an empty item now and then
      if ($urandom_range(0, 11) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Drain digest words with drawn stalls and one long hold-off
  initial begin
    int unsigned hold;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (words_seen % 8 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      hold = rx_burst ? 0 : $urandom_range(0, 15);
      if (words_seen == HOLD_AT) hold = LONG_HOLD;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      track.match_word(digest_word, word_number, last_word);
      words_seen++;
    end
  end

  // Guard against a hung run
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned edges [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    rst          = 1'b1;
    in_valid     = 1'b0;
    msg_byte     = 8'h00;
    byte_present = 1'b0;
    final_item   = 1'b0;
    out_stall    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty message, short messages, both ways of ending, extremes
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b0);
    send_item(8'h55, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // Random messages, weighted towards short ones and padding boundaries
    while (stream_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) len = $urandom_range(0, 12);
      else if (pick == 6) len = edges[$urandom_range(0, 9)];
      else if (pick == 7) len = $urandom_range(13, 130);
      else len = $urandom_range(0, 3);
      send_message(len, $urandom_range(0, 2) == 0);
    end
    in_valid <= 1'b0;

    // Wait for every owed word, then watch for strays
    while (track.due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (track.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

[sha256_hash_engine.f]
hdl/sha256_pkg.sv
hdl/sha256_msg.sv
hdl/sha256_core.sv
hdl/sha256_hash_engine.sv
tb/tb_sha256_hash_engine.sv
